### rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared sizes, opcodes and register indexes of the Bezier surface evaluator.
// ----------------------------------------------------------------------------
package bse_pkg;

    // grid and coordinate sizes
    localparam int MAX_SIDE   = 16;
    localparam int MAX_RES    = 1024;
    localparam int COORD_BITS = 24;
    localparam int COORD_FRAC = 8;

    localparam int SIDE_BITS  = $clog2(MAX_SIDE);
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int GRID_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int POINT_BITS = 3 * COORD_BITS;

    // field and register widths
    localparam int IDX_BITS      = 10;
    localparam int OP_BITS       = 2;
    localparam int SIDE_REG_BITS = 5;
    localparam int RES_REG_BITS  = 11;
    localparam int EXT_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // fixed point formats
    localparam int MU_FRAC   = 16;
    localparam int MU_BITS   = MU_FRAC + 1;
    localparam int W_FRAC    = 30;
    localparam int W_BITS    = W_FRAC + 1;
    localparam int MUL_BITS  = W_BITS + 2;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int ACC_BITS  = 64;
    localparam int SUM_BITS  = ACC_BITS - W_FRAC;

    // iterative divider sizes
    localparam int DIV_DEN_BITS = $clog2(2 * (MAX_RES - 1) + 1);
    localparam int MU_NUM_BITS  = $clog2(MAX_RES) + MU_BITS;
    localparam int SP_NUM_BITS  = SIDE_BITS + EXT_BITS + COORD_FRAC + 1;
    localparam int DIV_NUM_BITS = (MU_NUM_BITS > SP_NUM_BITS) ? MU_NUM_BITS : SP_NUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS + 1);

    // opcodes
    localparam logic [OP_BITS-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_EVAL  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FLAT  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NOP   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RES    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

endpackage

### rtl/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/bse_div.sv
// ----------------------------------------------------------------------------
// bse_div
// Restoring divider, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module bse_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bse_pkg::DIV_NUM_BITS-1:0]  num,
    input  logic [bse_pkg::DIV_DEN_BITS-1:0]  den,
    output logic [bse_pkg::DIV_NUM_BITS-1:0]  quot,
    output logic                              done
);
    import bse_pkg::*;

    logic [DIV_DEN_BITS-1:0] rem_reg;
    logic [DIV_DEN_BITS-1:0] den_reg;
    logic [DIV_NUM_BITS-1:0] quot_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_DEN_BITS:0]   shifted;
    logic [DIV_DEN_BITS:0]   trial;
    logic                    fits;

    // one trial subtraction per cycle
    assign shifted = {rem_reg, quot_reg[DIV_NUM_BITS-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_BITS'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(DIV_NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            den_reg  <= den;
            quot_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial[DIV_DEN_BITS-1:0] : shifted[DIV_DEN_BITS-1:0];
            quot_reg <= {quot_reg[DIV_NUM_BITS-2:0], fits};
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

### rtl/bse_mul.sv
// ----------------------------------------------------------------------------
// bse_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module bse_mul (
    input  logic                                clk,
    input  logic signed [bse_pkg::MUL_BITS-1:0] op_a,
    input  logic signed [bse_pkg::MUL_BITS-1:0] op_b,
    output logic signed [bse_pkg::PROD_BITS-1:0] prod
);
    import bse_pkg::*;

    logic signed [PROD_BITS-1:0] prod_reg;

    // product register
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

### rtl/bezier_surface_evaluator_unit.sv
// Write: taken in idle, ready stays high. Evaluate: two divisions, the
// Bernstein triangles and the weighted sum, paced by the shared multiplier
// (states B_MUL and B_WR per Bernstein step, phases WMUL to ZACC per point).
// Out of range evaluate: straight to finish. Flat reset: divide, sweep grid.
// One item at a time; ready is low while an item is in work.
// Reset: one grid sweep, flat plane inside the side, zeros outside it.
// ----------------------------------------------------------------------------
// bezier_surface_evaluator_unit
// Tensor product Bezier surface evaluator over a control grid of up to 16x16.
// ----------------------------------------------------------------------------
module bezier_surface_evaluator_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [bse_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [bse_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  logic                                     item_valid,
    output logic                                     item_ready,
    input  logic [bse_pkg::OP_BITS-1:0]              opcode,
    input  logic [bse_pkg::IDX_BITS-1:0]             row_index,
    input  logic [bse_pkg::IDX_BITS-1:0]             col_index,
    input  logic signed [bse_pkg::COORD_BITS-1:0]    point_x,
    input  logic signed [bse_pkg::COORD_BITS-1:0]    point_y,
    input  logic signed [bse_pkg::COORD_BITS-1:0]    point_z,
    output logic                                     result_valid,
    input  logic                                     result_ready,
    output logic signed [bse_pkg::COORD_BITS-1:0]    vertex_x,
    output logic signed [bse_pkg::COORD_BITS-1:0]    vertex_y,
    output logic signed [bse_pkg::COORD_BITS-1:0]    vertex_z,
    output logic                                     status
);
    import bse_pkg::*;

    localparam int SP_BITS = SIDE_BITS + EXT_BITS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FY_START = 4'd1;
    localparam logic [3:0] S_FY_WAIT  = 4'd2;
    localparam logic [3:0] S_FX_START = 4'd3;
    localparam logic [3:0] S_FX_WAIT  = 4'd4;
    localparam logic [3:0] S_FILL_WR  = 4'd5;
    localparam logic [3:0] S_MU_START = 4'd6;
    localparam logic [3:0] S_MU_WAIT  = 4'd7;
    localparam logic [3:0] S_B_MUL    = 4'd8;
    localparam logic [3:0] S_B_WR     = 4'd9;
    localparam logic [3:0] S_MAC      = 4'd10;
    localparam logic [3:0] S_FINISH   = 4'd11;

    localparam logic [2:0] PH_WMUL = 3'd0;
    localparam logic [2:0] PH_WRND = 3'd1;
    localparam logic [2:0] PH_XMUL = 3'd2;
    localparam logic [2:0] PH_YMUL = 3'd3;
    localparam logic [2:0] PH_ZMUL = 3'd4;
    localparam logic [2:0] PH_ZACC = 3'd5;

    localparam logic [W_BITS-1:0] W_ONE = W_BITS'(1) << W_FRAC;
    localparam logic signed [SUM_BITS-1:0] SUM_CMAX =
        SUM_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] SUM_CMIN = -SUM_CMAX - SUM_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(64'sd1 <<< (W_FRAC - 1));
    localparam logic [DIV_NUM_BITS-1:0] QUOT_CMAX =
        DIV_NUM_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);

    // configuration registers
    logic [SIDE_REG_BITS-1:0] side_cfg_reg;
    logic [RES_REG_BITS-1:0]  res_cfg_reg;
    logic [EXT_BITS-1:0]      width_cfg_reg;
    logic [EXT_BITS-1:0]      height_cfg_reg;

    // sequencer and loop state
    logic [3:0]            state_reg;
    logic                  init_reg;
    logic                  tgt_reg;
    logic                  err_reg;
    logic [SIDE_BITS-1:0]  cnt_a_reg;
    logic [SIDE_BITS-1:0]  cnt_b_reg;
    logic [SIDE_BITS-1:0]  m_reg;
    logic [SIDE_BITS-1:0]  k_reg;
    logic [2:0]            ph_reg;
    logic [IDX_BITS-1:0]   row_reg;
    logic [IDX_BITS-1:0]   col_reg;
    logic [MU_BITS-1:0]    mu_reg;
    logic [W_BITS-1:0]     prev_reg;
    logic [W_BITS-1:0]     lo_reg;
    logic [W_BITS-1:0]     w_reg;
    logic [COORD_BITS-1:0] x_fill_reg;
    logic [COORD_BITS-1:0] ys_reg [MAX_SIDE];
    logic [W_BITS-1:0]     wu_reg [MAX_SIDE];
    logic [W_BITS-1:0]     wv_reg [MAX_SIDE];
    logic signed [ACC_BITS-1:0] acc_x_reg;
    logic signed [ACC_BITS-1:0] acc_y_reg;
    logic signed [ACC_BITS-1:0] acc_z_reg;

    // result register
    logic                  result_valid_reg;
    logic [COORD_BITS-1:0] vx_reg;
    logic [COORD_BITS-1:0] vy_reg;
    logic [COORD_BITS-1:0] vz_reg;
    logic                  status_reg;

    // clamped configuration
    logic [SIDE_REG_BITS-1:0] side_now;
    logic [SIDE_BITS-1:0]     n_now;
    logic [RES_REG_BITS-1:0]  res_now;
    logic [IDX_BITS-1:0]      den_now;

    always_comb
    begin
        if (side_cfg_reg < SIDE_REG_BITS'(2))
        begin
            side_now = SIDE_REG_BITS'(2);
        end
        else if (side_cfg_reg > SIDE_REG_BITS'(MAX_SIDE))
        begin
            side_now = SIDE_REG_BITS'(MAX_SIDE);
        end
        else
        begin
            side_now = side_cfg_reg;
        end
        if (res_cfg_reg < RES_REG_BITS'(2))
        begin
            res_now = RES_REG_BITS'(2);
        end
        else if (res_cfg_reg > RES_REG_BITS'(MAX_RES))
        begin
            res_now = RES_REG_BITS'(MAX_RES);
        end
        else
        begin
            res_now = res_cfg_reg;
        end
    end

    assign n_now   = SIDE_BITS'(side_now - SIDE_REG_BITS'(1));
    assign den_now = IDX_BITS'(res_now - RES_REG_BITS'(1));

    // input handshake
    logic accept;
    logic wr_inside;
    logic eval_out;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign wr_inside  = (row_index < IDX_BITS'(side_now)) && (col_index < IDX_BITS'(side_now));
    assign eval_out   = (RES_REG_BITS'(row_index) >= res_now) ||
                        (RES_REG_BITS'(col_index) >= res_now);

    // divider operand selection
    logic                    div_start;
    logic [DIV_NUM_BITS-1:0] div_num;
    logic [DIV_DEN_BITS-1:0] div_den;
    logic [DIV_NUM_BITS-1:0] div_quot;
    logic                    div_done;
    logic [SIDE_BITS-1:0]    sp_idx;
    logic [EXT_BITS-1:0]     sp_ext;
    logic [SP_BITS-1:0]      sp_prod;
    logic [IDX_BITS-1:0]     mu_idx;
    logic                    row_in;

    assign row_in  = ({1'b0, cnt_a_reg} < side_now);
    assign sp_idx  = (state_reg == S_FY_START) ? cnt_b_reg : cnt_a_reg;
    assign sp_ext  = (state_reg == S_FY_START) ? height_cfg_reg : width_cfg_reg;
    assign sp_prod = SP_BITS'(sp_idx) * SP_BITS'(sp_ext);
    assign mu_idx  = tgt_reg ? col_reg : row_reg;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_FY_START, S_FX_START:
            begin
                div_start = (state_reg == S_FY_START) || row_in;
                div_num   = (DIV_NUM_BITS'(sp_prod) << (COORD_FRAC + 1)) +
                            DIV_NUM_BITS'(n_now);
                div_den   = DIV_DEN_BITS'({n_now, 1'b0});
            end
            S_MU_START:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_BITS'({mu_idx, {MU_BITS{1'b0}}}) + DIV_NUM_BITS'(den_now);
                div_den   = DIV_DEN_BITS'({den_now, 1'b0});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    bse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    logic [COORD_BITS-1:0] quot_sat;
    assign quot_sat = (div_quot > QUOT_CMAX) ? QUOT_CMAX[COORD_BITS-1:0]
                                             : div_quot[COORD_BITS-1:0];

    // control grid memory
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [POINT_BITS-1:0] ram_wdata;
    logic [POINT_BITS-1:0] ram_rdata;
    logic                  fill_inside;

    assign fill_inside = row_in && ({1'b0, cnt_b_reg} < side_now);

    always_comb
    begin
        if (state_reg == S_FILL_WR)
        begin
            ram_we    = init_reg || fill_inside;
            ram_waddr = {cnt_a_reg, cnt_b_reg};
            ram_wdata = fill_inside ? {COORD_BITS'(0), ys_reg[cnt_b_reg], x_fill_reg} : '0;
        end
        else
        begin
            ram_we    = accept && (opcode == OP_WRITE) && wr_inside;
            ram_waddr = {row_index[SIDE_BITS-1:0], col_index[SIDE_BITS-1:0]};
            ram_wdata = {point_z, point_y, point_x};
        end
    end

    bse_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr ({cnt_a_reg, cnt_b_reg}),
        .rd_data (ram_rdata)
    );

    // shared multiplier operands
    logic [W_BITS-1:0]             w_rd;
    logic [W_BITS-1:0]             lo_cur;
    logic signed [W_BITS:0]        diff;
    logic signed [MUL_BITS-1:0]    mul_a;
    logic signed [MUL_BITS-1:0]    mul_b;
    logic signed [PROD_BITS-1:0]   prod;
    logic [COORD_BITS-1:0]         coord_sel;

    assign w_rd   = tgt_reg ? wv_reg[k_reg] : wu_reg[k_reg];
    assign lo_cur = (k_reg < m_reg) ? w_rd : '0;
    assign diff   = $signed({1'b0, prev_reg}) - $signed({1'b0, lo_cur});

    always_comb
    begin
        case (ph_reg)
            PH_XMUL: coord_sel = ram_rdata[0 +: COORD_BITS];
            PH_YMUL: coord_sel = ram_rdata[COORD_BITS +: COORD_BITS];
            default: coord_sel = ram_rdata[2*COORD_BITS +: COORD_BITS];
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_B_MUL)
        begin
            mul_a = $signed(MUL_BITS'(mu_reg));
            mul_b = $signed({{(MUL_BITS-W_BITS-1){diff[W_BITS]}}, diff});
        end
        else if (state_reg == S_MAC)
        begin
            if (ph_reg == PH_WMUL)
            begin
                mul_a = $signed(MUL_BITS'(wu_reg[cnt_a_reg]));
                mul_b = $signed(MUL_BITS'(wv_reg[cnt_b_reg]));
            end
            else if ((ph_reg == PH_XMUL) || (ph_reg == PH_YMUL) || (ph_reg == PH_ZMUL))
            begin
                mul_a = $signed({{(MUL_BITS-COORD_BITS){coord_sel[COORD_BITS-1]}}, coord_sel});
                mul_b = $signed(MUL_BITS'(w_reg));
            end
        end
    end

    bse_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // rounding of products
    logic signed [PROD_BITS-1:0] bern_sum;
    logic [W_BITS-1:0]           w_new;
    logic [PROD_BITS-1:0]        wprod_rnd;
    logic signed [ACC_BITS-1:0]  prod_acc;

    assign bern_sum  = $signed(PROD_BITS'(lo_reg) << MU_FRAC) + prod +
                       $signed(PROD_BITS'(1) << (MU_FRAC - 1));
    assign w_new     = bern_sum[MU_FRAC +: W_BITS];
    assign wprod_rnd = prod + (PROD_BITS'(1) << (W_FRAC - 1));
    assign prod_acc  = prod[ACC_BITS-1:0];

    // final scaling and saturation
    function automatic logic [COORD_BITS-1:0] sat_acc(input logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS-1:0] rnd;
        logic signed [SUM_BITS-1:0] s;
        rnd = acc + ACC_HALF;
        s   = rnd[ACC_BITS-1:W_FRAC];
        if (s > SUM_CMAX)
        begin
            return SUM_CMAX[COORD_BITS-1:0];
        end
        else if (s < SUM_CMIN)
        begin
            return SUM_CMIN[COORD_BITS-1:0];
        end
        return s[COORD_BITS-1:0];
    endfunction

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_FY_START;
            init_reg         <= 1'b1;
            tgt_reg          <= 1'b0;
            err_reg          <= 1'b0;
            cnt_a_reg        <= '0;
            cnt_b_reg        <= '0;
            m_reg            <= '0;
            k_reg            <= '0;
            ph_reg           <= PH_WMUL;
            result_valid_reg <= 1'b0;
            side_cfg_reg     <= SIDE_REG_BITS'(4);
            res_cfg_reg      <= RES_REG_BITS'(64);
            width_cfg_reg    <= EXT_BITS'(1024);
            height_cfg_reg   <= EXT_BITS'(768);
        end
        else
        begin
            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SIDE:   side_cfg_reg   <= cfg_data[SIDE_REG_BITS-1:0];
                    CFG_RES:    res_cfg_reg    <= cfg_data[RES_REG_BITS-1:0];
                    CFG_WIDTH:  width_cfg_reg  <= cfg_data[EXT_BITS-1:0];
                    CFG_HEIGHT: height_cfg_reg <= cfg_data[EXT_BITS-1:0];
                    default:    side_cfg_reg   <= side_cfg_reg;
                endcase
            end

            // result word taken, unless a new one is loaded
            if (result_valid_reg && result_ready && (state_reg != S_FINISH))
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        row_reg <= row_index;
                        col_reg <= col_index;
                        case (opcode)
                            OP_EVAL:
                            begin
                                tgt_reg   <= 1'b0;
                                err_reg   <= eval_out;
                                state_reg <= eval_out ? S_FINISH : S_MU_START;
                            end
                            OP_FLAT:
                            begin
                                cnt_b_reg <= '0;
                                state_reg <= S_FY_START;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                // flat plane: column y values first, then rows
                S_FY_START:
                begin
                    state_reg <= S_FY_WAIT;
                end
                S_FY_WAIT:
                begin
                    if (div_done)
                    begin
                        ys_reg[cnt_b_reg] <= quot_sat;
                        if (cnt_b_reg == n_now)
                        begin
                            cnt_a_reg <= '0;
                            state_reg <= S_FX_START;
                        end
                        else
                        begin
                            cnt_b_reg <= cnt_b_reg + 1'b1;
                            state_reg <= S_FY_START;
                        end
                    end
                end
                S_FX_START:
                begin
                    if (row_in)
                    begin
                        state_reg <= S_FX_WAIT;
                    end
                    else
                    begin
                        x_fill_reg <= '0;
                        cnt_b_reg  <= '0;
                        state_reg  <= S_FILL_WR;
                    end
                end
                S_FX_WAIT:
                begin
                    if (div_done)
                    begin
                        x_fill_reg <= quot_sat;
                        cnt_b_reg  <= '0;
                        state_reg  <= S_FILL_WR;
                    end
                end
                S_FILL_WR:
                begin
                    if (cnt_b_reg == SIDE_BITS'(MAX_SIDE - 1))
                    begin
                        if (cnt_a_reg == SIDE_BITS'(MAX_SIDE - 1))
                        begin
                            init_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cnt_a_reg <= cnt_a_reg + 1'b1;
                            state_reg <= S_FX_START;
                        end
                    end
                    else
                    begin
                        cnt_b_reg <= cnt_b_reg + 1'b1;
                    end
                end

                // curve parameter by division
                S_MU_START:
                begin
                    state_reg <= S_MU_WAIT;
                end
                S_MU_WAIT:
                begin
                    if (div_done)
                    begin
                        mu_reg   <= div_quot[MU_BITS-1:0];
                        prev_reg <= '0;
                        m_reg    <= SIDE_BITS'(1);
                        k_reg    <= '0;
                        for (int i = 0; i < MAX_SIDE; i++)
                        begin
                            if (tgt_reg)
                            begin
                                wv_reg[i] <= (i == 0) ? W_ONE : '0;
                            end
                            else
                            begin
                                wu_reg[i] <= (i == 0) ? W_ONE : '0;
                            end
                        end
                        state_reg <= S_B_MUL;
                    end
                end

                // Bernstein triangle, one entry per B_MUL and B_WR pair
                S_B_MUL:
                begin
                    lo_reg    <= lo_cur;
                    state_reg <= S_B_WR;
                end
                S_B_WR:
                begin
                    if (tgt_reg)
                    begin
                        wv_reg[k_reg] <= w_new;
                    end
                    else
                    begin
                        wu_reg[k_reg] <= w_new;
                    end
                    if (k_reg == m_reg)
                    begin
                        if (m_reg == n_now)
                        begin
                            if (tgt_reg)
                            begin
                                cnt_a_reg <= '0;
                                cnt_b_reg <= '0;
                                ph_reg    <= PH_WMUL;
                                acc_x_reg <= '0;
                                acc_y_reg <= '0;
                                acc_z_reg <= '0;
                                state_reg <= S_MAC;
                            end
                            else
                            begin
                                tgt_reg   <= 1'b1;
                                state_reg <= S_MU_START;
                            end
                        end
                        else
                        begin
                            m_reg     <= m_reg + 1'b1;
                            k_reg     <= '0;
                            prev_reg  <= '0;
                            state_reg <= S_B_MUL;
                        end
                    end
                    else
                    begin
                        prev_reg  <= lo_reg;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_B_MUL;
                    end
                end

                // weighted sum over the control points
                S_MAC:
                begin
                    case (ph_reg)
                        PH_WMUL: ph_reg <= PH_WRND;
                        PH_WRND:
                        begin
                            w_reg  <= wprod_rnd[W_FRAC +: W_BITS];
                            ph_reg <= PH_XMUL;
                        end
                        PH_XMUL: ph_reg <= PH_YMUL;
                        PH_YMUL:
                        begin
                            acc_x_reg <= acc_x_reg + prod_acc;
                            ph_reg    <= PH_ZMUL;
                        end
                        PH_ZMUL:
                        begin
                            acc_y_reg <= acc_y_reg + prod_acc;
                            ph_reg    <= PH_ZACC;
                        end
                        default:
                        begin
                            acc_z_reg <= acc_z_reg + prod_acc;
                            ph_reg    <= PH_WMUL;
                            if (cnt_b_reg == n_now)
                            begin
                                cnt_b_reg <= '0;
                                if (cnt_a_reg == n_now)
                                begin
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    cnt_a_reg <= cnt_a_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cnt_b_reg <= cnt_b_reg + 1'b1;
                            end
                        end
                    endcase
                end

                // hand the word to the output register
                S_FINISH:
                begin
                    if (!result_valid_reg || result_ready)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FINISH) && (!result_valid_reg || result_ready))
        begin
            vx_reg     <= err_reg ? '0 : sat_acc(acc_x_reg);
            vy_reg     <= err_reg ? '0 : sat_acc(acc_y_reg);
            vz_reg     <= err_reg ? '0 : sat_acc(acc_z_reg);
            status_reg <= err_reg ? STATUS_RANGE : STATUS_OK;
        end
    end

    assign result_valid = result_valid_reg;
    assign vertex_x     = vx_reg;
    assign vertex_y     = vy_reg;
    assign vertex_z     = vz_reg;
    assign status       = status_reg;

endmodule

### rtl/bse_checker.sv
// ----------------------------------------------------------------------------
// bse_checker
// Port level checks of the Bezier surface evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bse_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic [bse_pkg::OP_BITS-1:0]       opcode,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [bse_pkg::COORD_BITS-1:0]    vertex_x,
    input logic [bse_pkg::COORD_BITS-1:0]    vertex_y,
    input logic [bse_pkg::COORD_BITS-1:0]    vertex_z,
    input logic                              status
);
    import bse_pkg::*;

    // a stalled result word keeps its x coordinate and status
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(vertex_x) && $stable(status))
    else $error("stalled result word changed");

    // range error carries a zero vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STATUS_RANGE) |->
            (vertex_x == '0) && (vertex_y == '0) && (vertex_z == '0))
    else $error("range error with nonzero vertex");

    // an evaluate word drops input ready in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (opcode == OP_EVAL) |=> !item_ready)
    else $error("input ready right after evaluate");

    // input ready stays high after a point write
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (opcode == OP_WRITE) |=> item_ready)
    else $error("input not ready after point write");

endmodule

bind bezier_surface_evaluator_unit bse_checker u_bse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .opcode       (opcode),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_z     (vertex_z),
    .status       (status)
);
